>>> sv/fap_pkg.sv
// Package for the first-fit page allocator.
// Holds result status codes and register map constants; no dependencies.
`default_nettype none

package fap_pkg;

  localparam int LEN_W = 16;
  localparam int LEN_CMP_W = LEN_W + 1;
  localparam int LIMIT_W = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_PAGE_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_LONG    = 2'd1,
    ST_NO_CAPACITY = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> sv/fap_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module fap_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/first_fit_page_allocator.sv
// First-fit page allocator top level: APB register, request FSM, result register.
// Depends on fap_pkg and fap_ram (space remaining per page).
//
//   channel   signals                                    direction
//   request   in_valid/in_ready, request_length          in
//   result    out_valid/out_ready, status, page_index,   out
//             byte_offset, open_page_count
//   config    psel/penable/pwrite/paddr/pwdata/prdata    APB
//
// A request that is too long, or that comes when no page is open yet, goes
// from IDLE straight to FINISH; else the scan reads one space entry per cycle from the
// RAM's single read port. One request is in flight at a time; the next one is
// taken while the previous result still waits in the output register.
// Reset clears the open count and sets page_limit to 64; the space RAM is not
// cleared, since only entries of opened pages are used.
`default_nettype none

module first_fit_page_allocator
  import fap_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_PAGES  = 64
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire logic                                            in_valid,
  output logic                                                 in_ready,
  input  wire logic [LEN_W-1:0]                                request_length,
  output logic                                                 out_valid,
  input  wire logic                                            out_ready,
  output logic [1:0]                                           status,
  output logic [(MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1)-1:0]   page_index,
  output logic [$clog2(PAGE_BYTES + 1)-1:0]                    byte_offset,
  output logic [$clog2(MAX_PAGES + 1)-1:0]                     open_page_count,
  input  wire logic                                            psel,
  input  wire logic                                            penable,
  input  wire logic                                            pwrite,
  input  wire logic [APB_ADDR_W-1:0]                           paddr,
  input  wire logic [APB_DATA_W-1:0]                           pwdata,
  output logic [APB_DATA_W-1:0]                                prdata,
  output logic                                                 pready
);

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int SW = $clog2(PAGE_BYTES + 1);
  localparam int LCW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t              state;
  logic [LIMIT_W-1:0]  page_limit;
  logic [CW-1:0]       pages_open;
  logic [LEN_W-1:0]    len;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       chosen;
  logic [SW-1:0]       space;
  status_t             result_status;
  logic                open_new;

  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;
  logic [SW-1:0]       space_next;
  logic                can_open;
  logic [LCW-1:0]      limit_eff;
  logic                fits;
  logic                scan_last;
  logic                fire;
  logic                cfg_write;

  // APB
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_PAGE_LIMIT) ? APB_DATA_W'(page_limit) : '0;

  // saturate the limit at the array depth
  assign limit_eff = (LCW'(page_limit) > LCW'(MAX_PAGES)) ? LCW'(MAX_PAGES)
                                                          : LCW'(page_limit);
  assign can_open  = LCW'(pages_open) < limit_eff;

  assign fits      = LEN_CMP_W'(ram_rdata) >= LEN_CMP_W'(len);
  assign scan_last = (CW'(idx) + CW'(1)) == pages_open;

  assign in_ready  = (state == IDLE);
  assign fire      = (state == FINISH) && (!out_valid || out_ready);

  // scan reads run one entry ahead of the compare
  assign ram_raddr  = (state == IDLE) ? '0 : idx + IW'(1);
  assign ram_we     = fire && (result_status == ST_OK);
  assign space_next = space - SW'(len);

  fap_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_PAGES)
  ) u_space (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chosen),
    .wdata (space_next),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      page_limit <= PAGE_LIMIT_RESET;
      pages_open <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_PAGE_LIMIT) begin
        page_limit <= pwdata[LIMIT_W-1:0];
      end

      if (out_valid && out_ready && !fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            len      <= request_length;
            idx      <= '0;
            open_new <= 1'b0;
            if (LEN_CMP_W'(request_length) > LEN_CMP_W'(PAGE_BYTES)) begin
              result_status <= ST_TOO_LONG;
              state         <= FINISH;
            end else if (pages_open == '0) begin
              chosen        <= '0;
              space         <= SW'(PAGE_BYTES);
              open_new      <= can_open;
              result_status <= can_open ? ST_OK : ST_NO_CAPACITY;
              state         <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end

        SCAN: begin
          if (fits) begin
            chosen        <= idx;
            space         <= ram_rdata;
            result_status <= ST_OK;
            state         <= FINISH;
          end else if (scan_last) begin
            chosen        <= IW'(pages_open);
            space         <= SW'(PAGE_BYTES);
            open_new      <= can_open;
            result_status <= can_open ? ST_OK : ST_NO_CAPACITY;
            state         <= FINISH;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        FINISH: begin
          if (fire) begin
            out_valid <= 1'b1;
            status    <= result_status;
            if (result_status == ST_OK) begin
              page_index  <= chosen;
              byte_offset <= SW'(PAGE_BYTES) - space;
            end else begin
              page_index  <= '0;
              byte_offset <= '0;
            end
            if (open_new) begin
              pages_open      <= pages_open + CW'(1);
              open_page_count <= pages_open + CW'(1);
            end else begin
              open_page_count <= pages_open;
            end
            state <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_first_fit_page_allocator.sv
// Testbench for first_fit_page_allocator: directed and random allocation requests
// under several page limits, scored against a first-fit model of the page table.
// Depends on fap_pkg and the allocator RTL; self-contained otherwise.
`default_nettype none

module tb_first_fit_page_allocator;
  import fap_pkg::*;

  localparam int PAGE_CAP   = 4096;
  localparam int PAGE_SLOTS = 64;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_PAGE_LIMIT, 2'b00};
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    status_t     status;
    logic [5:0]  page;
    logic [12:0] offset;
    logic [6:0]  count;
  } alloc_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKE} rx_mode_t;

  // First-fit model of the page table plus the queue of results it predicts.
  class alloc_scoreboard;
    logic [12:0]   space_left [PAGE_SLOTS];
    logic [6:0]    pages_open;
    logic [6:0]    page_limit;
    alloc_result_t expected_q [$];
    int            errors;

    function new();
      pages_open = '0;
      page_limit = PAGE_LIMIT_RESET;
      errors     = 0;
    endfunction

    function void set_limit(logic [6:0] value);
      page_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic [15:0] len);
      alloc_result_t r;
      logic [6:0]    eff_limit;
      int            i;
      int            pick;
      bit            found;
      r         = '0;
      r.status  = ST_OK;
      found     = 1'b0;
      pick      = 0;
      eff_limit = (page_limit > PAGE_SLOTS) ? 7'(PAGE_SLOTS) : page_limit;
      if (len > PAGE_CAP) begin
        r.status = ST_TOO_LONG;
      end else begin
        for (i = 0; i < pages_open; i++) begin
          if (!found && space_left[i] >= len) begin
            pick  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          if (pages_open < eff_limit) begin
            pick             = pages_open;
            space_left[pick] = 13'(PAGE_CAP);
            pages_open       = pages_open + 7'd1;
            found            = 1'b1;
          end else begin
            r.status = ST_NO_CAPACITY;
          end
        end
        if (found) begin
          r.page           = 6'(pick);
          r.offset         = 13'(PAGE_CAP) - space_left[pick];
          space_left[pick] = space_left[pick] - len[12:0];
        end
      end
      r.count = pages_open;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [5:0] pg, logic [12:0] off,
                               logic [6:0] cnt);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: status %0d page %0d offset %0d", st, pg, off);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (st != e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (pg != e.page) begin
        $error("page_index mismatch: expected %0d, actual %0d", e.page, pg);
        errors++;
      end
      if (off != e.offset) begin
        $error("byte_offset mismatch: expected %0d, actual %0d", e.offset, off);
        errors++;
      end
      if (cnt != e.count) begin
        $error("open_page_count mismatch: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [LEN_W-1:0]      request_length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [5:0]            page_index;
  logic [12:0]           byte_offset;
  logic [6:0]            open_page_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  alloc_scoreboard sb;
  logic [15:0]     length_q [$];
  int              burst_left;
  int              rx_cycles;
  int              stall_left;

  first_fit_page_allocator #(
    .PAGE_BYTES(PAGE_CAP),
    .MAX_PAGES (PAGE_SLOTS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .request_length (request_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .page_index     (page_index),
    .byte_offset    (byte_offset),
    .open_page_count(open_page_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor: results first, since a result can never belong to a request
  // accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(status, page_index, byte_offset, open_page_count);
      end
      if (in_valid && in_ready) begin
        sb.note_request(request_length);
      end
    end
  end

  // Result side back-pressure: open, random, and long choke stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      rx_cycles  = 0;
      stall_left = 0;
    end else begin
      rx_cycles++;
      case (rx_mode_t'((rx_cycles / 300) % 3))
        RX_OPEN: begin
          out_ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_ready <= ($urandom_range(3) != 0);
        end
        default: begin
          if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left--;
          end else begin
            out_ready  <= 1'b1;
            stall_left = $urandom_range(12, 1);
          end
        end
      endcase
    end
  end

  function automatic logic [15:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return 16'($urandom_range(65535, PAGE_CAP + 1));
    end else if (roll < 14) begin
      case ($urandom_range(3))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'(PAGE_CAP - 1);
        default: return 16'(PAGE_CAP);
      endcase
    end else if (roll < 44) begin
      return 16'($urandom_range(PAGE_CAP, 1024));
    end else if (roll < 74) begin
      return 16'($urandom_range(1023, 128));
    end
    return 16'($urandom_range(127, 0));
  endfunction

  function automatic int new_burst();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(40, 20);
    end
    return $urandom_range(6, 1);
  endfunction

  // Holds one request until accepted; a gap follows when the burst runs out.
  // last_one closes the burst without a gap so the caller can drain.
  task automatic drive_request(input logic [15:0] len, input bit last_one);
    in_valid       <= 1'b1;
    request_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (last_one || burst_left <= 0) begin
      in_valid <= 1'b0;
      if (!last_one) begin
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end
      burst_left = new_burst();
    end
  endtask

  task automatic play_queue();
    logic [15:0] len;
    while (length_q.size() != 0) begin
      len = length_q.pop_front();
      drive_request(len, length_q.size() == 0);
    end
  endtask

  task automatic play_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      drive_request(pick_length(), n == count - 1);
    end
  endtask

  // Valid is already low here; the first wait lets the monitor log the last request.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_page_limit(input logic [6:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // read back
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != {25'd0, value}) begin
      $error("page_limit readback mismatch: expected %0d, actual %0d", value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    sb         = new();
    burst_left = new_burst();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no page may open: everything fails, too long or no capacity
    set_page_limit(7'd0);
    length_q = '{16'd0, 16'd1, 16'd4096, 16'd4097, 16'hFFFF, 16'h8000, 16'h5555, 16'h2AAA};
    play_queue();
    wait_drained();

    // single page: exact fill, zero length at the full mark, then overflow
    set_page_limit(7'd1);
    length_q = '{16'd0, 16'd4096, 16'd0, 16'd1, 16'd4097};
    play_queue();
    play_random(15);
    wait_drained();

    set_page_limit(7'd3);
    length_q = '{16'd100, 16'd4000, 16'd96, 16'd3996, 16'd1, 16'd2048, 16'd2048, 16'd0};
    play_queue();
    play_random(40);
    wait_drained();

    // above the page count: saturates, lets every page open
    set_page_limit(7'd127);
    play_random(320);
    wait_drained();

    set_page_limit(7'd64);
    play_random(40);
    wait_drained();

    // limit below the open count: only gaps in open pages can be used
    set_page_limit(7'd1);
    play_random(30);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
sv/fap_pkg.sv
sv/fap_ram.sv
sv/first_fit_page_allocator.sv
sim/tb_first_fit_page_allocator.sv
